// ===== rtl/core/jhsp_pkg.sv =====
// ----------------------------------------------------------------------------
// jhsp_pkg
// shared types and codes of the jpeg header segment parser
// ----------------------------------------------------------------------------
`default_nettype none
package jhsp_pkg;
	localparam logic [3:0] PH_IDLE   = 4'd0;
	localparam logic [3:0] PH_LEN    = 4'd1;
	localparam logic [3:0] PH_HEAD   = 4'd2;
	localparam logic [3:0] PH_CA     = 4'd3;
	localparam logic [3:0] PH_CB     = 4'd4;
	localparam logic [3:0] PH_CC     = 4'd5;
	localparam logic [3:0] PH_TA     = 4'd6;
	localparam logic [3:0] PH_TB     = 4'd7;
	localparam logic [3:0] PH_TC     = 4'd8;
	localparam logic [3:0] PH_TABHDR = 4'd9;
	localparam logic [3:0] PH_HI     = 4'd10;
	localparam logic [3:0] PH_LO     = 4'd11;
	localparam logic [3:0] PH_COUNTS = 4'd12;
	localparam logic [3:0] PH_SYMS   = 4'd13;

	localparam logic [2:0] K_JFIF  = 3'd0;
	localparam logic [2:0] K_COM   = 3'd1;
	localparam logic [2:0] K_FRAME = 3'd2;
	localparam logic [2:0] K_SCAN  = 3'd3;
	localparam logic [2:0] K_QUANT = 3'd4;
	localparam logic [2:0] K_HUFF  = 3'd5;

	localparam logic [4:0] T_VER = 5'd0, T_UNITS = 5'd1, T_XD = 5'd2, T_YD = 5'd3;
	localparam logic [4:0] T_THUMB = 5'd4, T_COM = 5'd5, T_PREC = 5'd6, T_LINES = 5'd7;
	localparam logic [4:0] T_SPL = 5'd8, T_NCOMP = 5'd9, T_FCOMP = 5'd10;
	localparam logic [4:0] T_SCNT = 5'd11, T_SCOMP = 5'd12, T_SPEC = 5'd13;
	localparam logic [4:0] T_QCOEF = 5'd14, T_HCNT = 5'd15, T_HSYM = 5'd16;

	typedef struct packed {
		logic [4:0]  tag;
		logic [7:0]  key;
		logic [15:0] value_a;
		logic [7:0]  value_b;
		logic [7:0]  value_c;
		logic [3:0]  value_d;
		logic [7:0]  position;
		logic        error;
		logic        segment_done;
	} report_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] data_byte;
		logic       segment_start;
		logic [3:0] process_type;
	} beat_t;
endpackage
`default_nettype wire

// ===== rtl/core/jhsp_core.sv =====
// ----------------------------------------------------------------------------
// jhsp_core
// parser state and per-byte decode; state updates when a byte steps, its report comes in the same cycle
// ----------------------------------------------------------------------------
`default_nettype none
module jhsp_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire jhsp_pkg::beat_t  beat,
	output logic                  rep_valid,
	output jhsp_pkg::report_t     rep
);
	import jhsp_pkg::*;

	logic [2:0]  kind_q;
	logic [15:0] cnt_q, rem_q;
	logic [7:0]  held_q, id_q, total_q;
	logic [3:0]  cls_q, prec_q, phase_q;
	logic [11:0] idx_q, sym_q;

	logic [2:0]  kind_d;
	logic [15:0] cnt_d, rem_d;
	logic [7:0]  held_d, id_d, total_d;
	logic [3:0]  cls_d, prec_d, phase_d;
	logic [11:0] idx_d, sym_d;

	logic [7:0]  b;
	logic [15:0] len, hb, need;
	logic [11:0] idx_inc, sym_sum;
	logic        emit;
	report_t     r;

	assign b  = beat.data_byte;
	assign hb = {held_q, b};
	assign idx_inc = idx_q + 12'd1;
	assign sym_sum = sym_q + {4'd0, b};

	always_comb begin
		kind_d = kind_q; cnt_d = cnt_q; rem_d = rem_q; held_d = held_q; id_d = id_q;
		total_d = total_q; cls_d = cls_q; prec_d = prec_q; phase_d = phase_q;
		idx_d = idx_q; sym_d = sym_q;
		emit = 1'b0;
		r = '0;
		len = hb;
		need = '0;
		if (beat.segment_start) begin
			kind_d = beat.kind; held_d = b; cnt_d = 16'd1; rem_d = '0; id_d = '0;
			cls_d = '0; prec_d = '0; idx_d = '0; sym_d = '0; total_d = '0;
			phase_d = (beat.kind <= K_HUFF) ? PH_LEN : PH_IDLE;
		end else if (phase_q != PH_IDLE) begin
			cnt_d = cnt_q + 16'd1;
			unique case (phase_q)
				PH_LEN: begin
					if (kind_q == K_JFIF || kind_q == K_FRAME || kind_q == K_SCAN) begin
						phase_d = PH_HEAD;
					end else begin
						rem_d = (len < 16'd2) ? 16'd0 : len - 16'd2;
						if (rem_d == 16'd0) phase_d = PH_IDLE;
						else phase_d = (kind_q == K_COM) ? PH_HEAD : PH_TABHDR;
					end
				end
				PH_HEAD: begin
					if (kind_q == K_JFIF) begin
						case (cnt_q)
							16'd2, 16'd3, 16'd4, 16'd5, 16'd6: begin
								if (b != ((cnt_q == 16'd2) ? 8'h4A :
								          (cnt_q == 16'd4) ? 8'h49 :
								          (cnt_q == 16'd6) ? 8'h00 : 8'h46)) begin
									emit = 1'b1; r.error = 1'b1; r.segment_done = 1'b1;
								end
							end
							16'd7, 16'd10, 16'd12, 16'd14: held_d = b;
							16'd8:  begin emit = 1'b1; r.tag = T_VER; r.value_a = hb; end
							16'd9:  begin emit = 1'b1; r.tag = T_UNITS; r.value_a = {8'd0, b}; end
							16'd11: begin emit = 1'b1; r.tag = T_XD; r.value_a = hb; end
							16'd13: begin emit = 1'b1; r.tag = T_YD; r.value_a = hb; end
							16'd15: begin
								emit = 1'b1; r.tag = T_THUMB; r.value_a = {8'd0, held_q};
								r.value_b = b; r.segment_done = 1'b1;
							end
							default: ;
						endcase
					end else if (kind_q == K_FRAME) begin
						case (cnt_q)
							16'd2: begin
								emit = 1'b1; r.tag = T_PREC; r.value_a = {8'd0, b};
								r.value_c = {4'd0, beat.process_type};
							end
							16'd3, 16'd5: held_d = b;
							16'd4: begin emit = 1'b1; r.tag = T_LINES; r.value_a = hb; end
							16'd6: begin emit = 1'b1; r.tag = T_SPL; r.value_a = hb; end
							16'd7: begin
								total_d = b; idx_d = '0; phase_d = PH_CA;
								emit = 1'b1; r.tag = T_NCOMP; r.value_a = {8'd0, b};
								r.segment_done = (b == 8'd0);
							end
							default: ;
						endcase
					end else if (kind_q == K_SCAN) begin
						total_d = b; idx_d = '0;
						phase_d = (b == 8'd0) ? PH_TA : PH_CA;
						emit = 1'b1; r.tag = T_SCNT; r.value_a = {8'd0, b};
					end else begin
						rem_d = rem_q - 16'd1;
						emit = 1'b1; r.tag = T_COM; r.value_a = {8'd0, b};
						r.position = 8'(cnt_q - 16'd2);
						r.segment_done = (rem_d == 16'd0);
					end
				end
				PH_CA: begin id_d = b; phase_d = PH_CB; end
				PH_CB: begin
					if (kind_q == K_FRAME) begin
						held_d = b; phase_d = PH_CC;
					end else begin
						idx_d = idx_inc;
						phase_d = (idx_inc >= {4'd0, total_q}) ? PH_TA : PH_CA;
						emit = 1'b1; r.tag = T_SCOMP; r.key = id_q;
						r.value_a = {12'd0, b[7:4]}; r.value_b = {4'd0, b[3:0]};
					end
				end
				PH_CC: begin
					idx_d = idx_inc; phase_d = PH_CA;
					emit = 1'b1; r.tag = T_FCOMP; r.key = id_q;
					r.value_a = {12'd0, held_q[7:4]}; r.value_b = {4'd0, held_q[3:0]};
					r.value_c = b; r.segment_done = (idx_inc >= {4'd0, total_q});
				end
				PH_TA: begin id_d = b; phase_d = PH_TB; end
				PH_TB: begin held_d = b; phase_d = PH_TC; end
				PH_TC: begin
					emit = 1'b1; r.tag = T_SPEC; r.value_a = {8'd0, id_q};
					r.value_b = held_q; r.value_c = {4'd0, b[7:4]}; r.value_d = b[3:0];
					r.segment_done = 1'b1;
				end
				PH_TABHDR: begin
					id_d = {4'd0, b[3:0]}; idx_d = '0;
					if (kind_q == K_QUANT) begin
						prec_d = b[7:4];
						need = (b[7:4] == 4'd1) ? 16'd129 : 16'd65;
						rem_d = (rem_q < need) ? 16'd0 : rem_q - need;
						phase_d = (b[7:4] == 4'd1) ? PH_HI : PH_LO;
					end else begin
						cls_d = b[7:4]; sym_d = '0; phase_d = PH_COUNTS;
					end
				end
				PH_HI: begin held_d = b; phase_d = PH_LO; end
				PH_LO: begin
					idx_d = idx_inc;
					emit = 1'b1; r.tag = T_QCOEF; r.key = id_q;
					r.value_a = (prec_q == 4'd1) ? hb : {8'd0, b};
					r.value_b = {4'd0, prec_q}; r.position = idx_q[7:0];
					if (idx_inc >= 12'd64) begin
						if (rem_q == 16'd0) r.segment_done = 1'b1;
						else phase_d = PH_TABHDR;
					end else begin
						phase_d = (prec_q == 4'd1) ? PH_HI : PH_LO;
					end
				end
				PH_COUNTS: begin
					sym_d = sym_sum; idx_d = idx_inc;
					emit = 1'b1; r.tag = T_HCNT; r.key = id_q; r.value_a = {8'd0, b};
					r.value_b = {4'd0, cls_q}; r.position = idx_q[7:0];
					if (idx_inc >= 12'd16) begin
						need = 16'd17 + {4'd0, sym_sum};
						rem_d = (rem_q < need) ? 16'd0 : rem_q - need;
						idx_d = '0;
						if (sym_sum == 12'd0) begin
							if (rem_d == 16'd0) r.segment_done = 1'b1;
							else phase_d = PH_TABHDR;
						end else begin
							phase_d = PH_SYMS;
						end
					end
				end
				PH_SYMS: begin
					idx_d = idx_inc;
					emit = 1'b1; r.tag = T_HSYM; r.key = id_q; r.value_a = {8'd0, b};
					r.value_b = {4'd0, cls_q}; r.position = idx_q[7:0];
					if (idx_inc >= sym_q) begin
						if (rem_q == 16'd0) r.segment_done = 1'b1;
						else phase_d = PH_TABHDR;
					end
				end
				default: ;
			endcase
			if (emit && r.segment_done) phase_d = PH_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= '0; cnt_q <= '0; rem_q <= '0; held_q <= '0; id_q <= '0;
			total_q <= '0; cls_q <= '0; prec_q <= '0; phase_q <= PH_IDLE;
			idx_q <= '0; sym_q <= '0;
		end else if (step) begin
			kind_q <= kind_d; cnt_q <= cnt_d; rem_q <= rem_d; held_q <= held_d;
			id_q <= id_d; total_q <= total_d; cls_q <= cls_d; prec_q <= prec_d;
			phase_q <= phase_d; idx_q <= idx_d; sym_q <= sym_d;
		end
	end

	assign rep_valid = emit;
	assign rep = r;
endmodule
`default_nettype wire

// ===== rtl/core/jpeg_header_segment_parser.sv =====
// ----------------------------------------------------------------------------
// jpeg_header_segment_parser
// parses jpeg header segment bytes into field reports
// ----------------------------------------------------------------------------
// One byte per beat; a new byte is taken every cycle unless the output
// register holds a report that is not taken and the input register holds a
// byte that yields a report. A byte enters an input register, its state update
// and report decode are combinational from there, and when the byte steps the
// report lands in the output register.
`default_nettype none
module jpeg_header_segment_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // data_byte[7:0], process_type[11:8], zeros
	input  wire logic [3:0]  s_tuser,   // kind[2:0], segment_start[3]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [55:0]      m_tdata,   // key, value_a, value_b, value_c,
	                                    // value_d, position, zeros
	output logic [5:0]       m_tuser,   // tag[4:0], error[5]
	output logic             m_tlast    // segment_done
);
	import jhsp_pkg::*;

	beat_t   beat_s1;
	logic    valid_s1;
	logic    rep_valid;
	report_t rep;
	report_t out_q;
	logic    out_valid_q;
	logic    step;

	// s1 advances when the output register can take what it produces
	assign step = valid_s1 && (!out_valid_q || m_tready || !rep_valid);
	assign s_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			beat_s1 <= '{kind: s_tuser[2:0], data_byte: s_tdata[7:0],
			             segment_start: s_tuser[3], process_type: s_tdata[11:8]};
		end
	end

	jhsp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.beat      (beat_s1),
		.rep_valid (rep_valid),
		.rep       (rep)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && rep_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && rep_valid) out_q <= rep;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_q.position, out_q.value_d, out_q.value_c,
	                   out_q.value_b, out_q.value_a, out_q.key};
	assign m_tuser  = {out_q.error, out_q.tag};
	assign m_tlast  = out_q.segment_done;
endmodule
`default_nettype wire

// ===== test/jpeg_header_segment_parser_test.sv =====
// ----------------------------------------------------------------------------
// jpeg_header_segment_parser_test
// Sends whole header segments of every kind through the parser: well-formed
// segments with random content, plus bad identifiers, short lengths, table
// wraps, cut-off segments, unknown kinds and stray bytes. Each accepted byte
// is run through a parser model in the bench. Each report is checked field by
// field against the oldest predicted report. Both sides stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module jpeg_header_segment_parser_test;
	import jhsp_pkg::*;

	localparam int IDLE_LIMIT = 4000;

	typedef struct {
		logic [2:0] kind;
		logic [7:0] data_byte;
		bit         start;
		logic [3:0] process_type;
		bit         drain;
	} header_byte_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic [3:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;
	logic [5:0]  m_tuser;
	logic        m_tlast;

	jpeg_header_segment_parser uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always #5 clk = ~clk;

	header_byte_t header_bytes[$];
	header_byte_t segment_bytes[$];
	report_t      expected_reports[$];
	int           mismatches = 0;
	int           reports_seen = 0;
	int           idle_cycles = 0;

	// ---------------- parser model ----------------
	logic [2:0]  seg_kind;
	logic [15:0] seg_pos, seg_left;
	logic [7:0]  held, cur_id, n_items;
	logic [3:0]  tclass, pq, ph;
	logic [11:0] ent, sym_total;
	logic [7:0]  jfif_id [5] = '{8'h4A, 8'h46, 8'h49, 8'h46, 8'h00};

	task automatic use_length(input logic [15:0] need);
		seg_left = (seg_left < need) ? 16'd0 : seg_left - need;
	endtask

	task automatic table_end(output bit done);
		done = (seg_left == 16'd0);
		if (!done)
			ph = PH_TABHDR;
	endtask

	task automatic parse_byte(input logic [2:0] k, input logic [7:0] b, input bit st,
			input logic [3:0] pt);
		report_t     r;
		bit          got;
		bit          done;
		logic [15:0] idx;
		logic [15:0] len;
		r = '0;
		got = 0;
		done = 0;
		if (st) begin
			seg_kind = k; held = b; seg_pos = 16'd1; seg_left = '0;
			cur_id = '0; tclass = '0; pq = '0; ent = '0; sym_total = '0; n_items = '0;
			ph = (k <= K_HUFF) ? PH_LEN : PH_IDLE;
		end else if (ph != PH_IDLE) begin
			idx = seg_pos;
			seg_pos = seg_pos + 16'd1;
			case (ph)
				PH_LEN: begin
					len = {held, b};
					if (seg_kind == K_JFIF || seg_kind == K_FRAME || seg_kind == K_SCAN) begin
						ph = PH_HEAD;
					end else begin
						seg_left = (len < 16'd2) ? 16'd0 : len - 16'd2;
						if (seg_left == 16'd0)
							ph = PH_IDLE;
						else
							ph = (seg_kind == K_COM) ? PH_HEAD : PH_TABHDR;
					end
				end
				PH_HEAD: begin
					if (seg_kind == K_JFIF) begin
						if (idx >= 16'd2 && idx <= 16'd6) begin
							if (b != jfif_id[3'(idx - 16'd2)]) begin
								got = 1; r.tag = T_VER; r.error = 1'b1; done = 1;
							end
						end else case (idx)
							16'd7, 16'd10, 16'd12, 16'd14: held = b;
							16'd8: begin got = 1; r.tag = T_VER; r.value_a = {held, b}; end
							16'd9: begin got = 1; r.tag = T_UNITS; r.value_a = {8'd0, b}; end
							16'd11: begin got = 1; r.tag = T_XD; r.value_a = {held, b}; end
							16'd13: begin got = 1; r.tag = T_YD; r.value_a = {held, b}; end
							16'd15: begin
								got = 1; r.tag = T_THUMB; r.value_a = {8'd0, held};
								r.value_b = b; done = 1;
							end
							default: ;
						endcase
					end else if (seg_kind == K_FRAME) begin
						case (idx)
							16'd2: begin
								got = 1; r.tag = T_PREC; r.value_a = {8'd0, b};
								r.value_c = {4'd0, pt};
							end
							16'd3, 16'd5: held = b;
							16'd4: begin got = 1; r.tag = T_LINES; r.value_a = {held, b}; end
							16'd6: begin got = 1; r.tag = T_SPL; r.value_a = {held, b}; end
							16'd7: begin
								n_items = b; ent = '0; ph = PH_CA;
								got = 1; r.tag = T_NCOMP; r.value_a = {8'd0, b};
								done = (b == 8'd0);
							end
							default: ;
						endcase
					end else if (seg_kind == K_SCAN) begin
						n_items = b; ent = '0;
						ph = (b == 8'd0) ? PH_TA : PH_CA;
						got = 1; r.tag = T_SCNT; r.value_a = {8'd0, b};
					end else begin
						seg_left = seg_left - 16'd1;
						got = 1; r.tag = T_COM; r.value_a = {8'd0, b};
						r.position = 8'(idx - 16'd2);
						done = (seg_left == 16'd0);
					end
				end
				PH_CA: begin cur_id = b; ph = PH_CB; end
				PH_CB: begin
					if (seg_kind == K_FRAME) begin
						held = b; ph = PH_CC;
					end else begin
						ent = ent + 12'd1;
						ph = (ent >= {4'd0, n_items}) ? PH_TA : PH_CA;
						got = 1; r.tag = T_SCOMP; r.key = cur_id;
						r.value_a = {12'd0, b[7:4]}; r.value_b = {4'd0, b[3:0]};
					end
				end
				PH_CC: begin
					ent = ent + 12'd1; ph = PH_CA;
					got = 1; r.tag = T_FCOMP; r.key = cur_id; r.value_a = {12'd0, held[7:4]};
					r.value_b = {4'd0, held[3:0]}; r.value_c = b;
					done = (ent >= {4'd0, n_items});
				end
				PH_TA: begin cur_id = b; ph = PH_TB; end
				PH_TB: begin held = b; ph = PH_TC; end
				PH_TC: begin
					got = 1; r.tag = T_SPEC; r.value_a = {8'd0, cur_id}; r.value_b = held;
					r.value_c = {4'd0, b[7:4]}; r.value_d = b[3:0]; done = 1;
				end
				PH_TABHDR: begin
					cur_id = {4'd0, b[3:0]}; ent = '0;
					if (seg_kind == K_QUANT) begin
						pq = b[7:4];
						use_length(pq == 4'd1 ? 16'd129 : 16'd65);
						ph = (pq == 4'd1) ? PH_HI : PH_LO;
					end else begin
						tclass = b[7:4]; sym_total = '0; ph = PH_COUNTS;
					end
				end
				PH_HI: begin held = b; ph = PH_LO; end
				PH_LO: begin
					got = 1; r.tag = T_QCOEF; r.key = cur_id; r.value_b = {4'd0, pq};
					r.value_a = (pq == 4'd1) ? {held, b} : {8'd0, b};
					r.position = ent[7:0];
					ent = ent + 12'd1;
					if (ent >= 12'd64)
						table_end(done);
					else
						ph = (pq == 4'd1) ? PH_HI : PH_LO;
				end
				PH_COUNTS: begin
					got = 1; r.tag = T_HCNT; r.key = cur_id; r.value_a = {8'd0, b};
					r.value_b = {4'd0, tclass}; r.position = ent[7:0];
					sym_total = sym_total + {4'd0, b};
					ent = ent + 12'd1;
					if (ent >= 12'd16) begin
						use_length(16'd17 + {4'd0, sym_total});
						ent = '0;
						if (sym_total == 12'd0)
							table_end(done);
						else
							ph = PH_SYMS;
					end
				end
				PH_SYMS: begin
					got = 1; r.tag = T_HSYM; r.key = cur_id; r.value_a = {8'd0, b};
					r.value_b = {4'd0, tclass}; r.position = ent[7:0];
					ent = ent + 12'd1;
					if (ent >= sym_total)
						table_end(done);
				end
				default: ;
			endcase
			if (got) begin
				r.segment_done = done;
				expected_reports.insert(expected_reports.size(), r);
				if (done)
					ph = PH_IDLE;
			end
		end
	endtask

	// ---------------- stimulus building ----------------
	task automatic put(input logic [7:0] b);
		header_byte_t hb;
		hb.kind = 3'($urandom); hb.data_byte = b; hb.start = 0;
		hb.process_type = 4'($urandom); hb.drain = 0;
		segment_bytes.insert(segment_bytes.size(), hb);
	endtask

	task automatic open_seg(input logic [2:0] k, input logic [15:0] len);
		header_byte_t hb;
		hb.kind = k; hb.data_byte = len[15:8]; hb.start = 1;
		hb.process_type = 4'($urandom); hb.drain = 0;
		segment_bytes.insert(segment_bytes.size(), hb);
		put(len[7:0]);
	endtask

	// cut: drop the tail so the next start lands mid-segment; junk: trailing noise
	task automatic flush_seg(input bit cut, input int junk, input bit drain);
		int keep;
		keep = segment_bytes.size();
		if (cut && keep > 2)
			keep = $urandom_range(2, keep - 1);
		if (drain)
			segment_bytes[0].drain = 1;
		for (int i = 0; i < keep; i++)
			header_bytes.insert(header_bytes.size(), segment_bytes[i]);
		segment_bytes.delete();
		repeat (junk) begin
			put(8'($urandom));
			header_bytes.insert(header_bytes.size(), segment_bytes[0]);
			segment_bytes.delete();
		end
	endtask

	task automatic seg_jfif(input int bad_at);
		open_seg(K_JFIF, 16'($urandom));
		for (int i = 0; i < 5; i++)
			put(i == bad_at ? jfif_id[i] ^ (8'd1 << $urandom_range(0, 7)) : jfif_id[i]);
		repeat (9) put(8'($urandom));
	endtask

	task automatic seg_com(input int n, input logic [15:0] len);
		open_seg(K_COM, len);
		repeat (n) put(8'($urandom));
	endtask

	task automatic seg_frame(input int nc);
		open_seg(K_FRAME, 16'($urandom));
		repeat (5) put(8'($urandom));
		put(8'(nc));
		repeat (nc * 3) put(8'($urandom));
	endtask

	task automatic seg_scan(input int nc);
		open_seg(K_SCAN, 16'($urandom));
		put(8'(nc));
		repeat (nc * 2 + 3) put(8'($urandom));
	endtask

	// short: give a length below what the tables need, forcing a wrap
	task automatic seg_quant(input int ntab, input bit short);
		int   total;
		logic [3:0] p [4];
		total = 0;
		for (int t = 0; t < ntab; t++) begin
			p[t] = ($urandom_range(0, 2) == 0) ? 4'd1 : 4'($urandom);
			total += (p[t] == 1) ? 129 : 65;
		end
		open_seg(K_QUANT, 16'(short ? $urandom_range(3, total + 1) : total + 2));
		for (int t = 0; t < ntab; t++) begin
			put({p[t], 4'($urandom)});
			repeat ((p[t] == 1) ? 128 : 64) put(8'($urandom));
		end
	endtask

	task automatic seg_huff(input int ntab, input int max_count, input bit short);
		int   total;
		int   cnt [4][16];
		int   nsym [4];
		total = 0;
		for (int t = 0; t < ntab; t++) begin
			nsym[t] = 0;
			for (int i = 0; i < 16; i++) begin
				cnt[t][i] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, max_count) : 0;
				nsym[t] += cnt[t][i];
			end
			total += 17 + nsym[t];
		end
		open_seg(K_HUFF, 16'(short ? $urandom_range(3, total + 1) : total + 2));
		for (int t = 0; t < ntab; t++) begin
			put(8'($urandom));
			for (int i = 0; i < 16; i++)
				put(8'(cnt[t][i]));
			repeat (nsym[t]) put(8'($urandom));
		end
	endtask

	// ---------------- sender ----------------
	int tx_wait;
	bit tx_burst;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 0;
			s_tdata <= '0;
			s_tuser <= '0;
			tx_wait <= 0;
			tx_burst <= 0;
		end else if (s_tvalid && !s_tready) begin
			// hold the offered beat
		end else if (tx_wait > 0) begin
			s_tvalid <= 0;
			tx_wait <= tx_wait - 1;
		end else if (header_bytes.size() == 0 ||
				(header_bytes[0].drain && (s_tvalid || expected_reports.size() != 0))) begin
			s_tvalid <= 0;
		end else begin
			header_byte_t hb;
			hb = header_bytes.pop_front();
			s_tdata <= {4'd0, hb.process_type, hb.data_byte};
			s_tuser <= {hb.start, hb.kind};
			s_tvalid <= 1;
			if ($urandom_range(0, 60) == 0)
				tx_burst <= !tx_burst;
			tx_wait <= tx_burst ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(0, 14) : 0);
		end
	end

	// ---------------- receiver ----------------
	int rx_wait;
	bit rx_burst;
	bit long_done;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 0;
			rx_wait <= 0;
			rx_burst <= 0;
			long_done <= 0;
		end else if (!long_done && reports_seen >= 150) begin
			// long hold so the parser backs up into its input
			long_done <= 1;
			rx_wait <= 400;
			m_tready <= 0;
		end else if (m_tvalid && m_tready) begin
			int w;
			w = rx_burst ? 0 : ($urandom_range(0, 2) == 0 ? $urandom_range(0, 14) : 0);
			if ($urandom_range(0, 60) == 0)
				rx_burst <= !rx_burst;
			rx_wait <= w;
			m_tready <= (w == 0);
		end else if (rx_wait > 0) begin
			rx_wait <= rx_wait - 1;
			m_tready <= (rx_wait == 1);
		end else begin
			m_tready <= 1;
		end
	end

	// ---------------- checker ----------------
	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				parse_byte(s_tuser[2:0], s_tdata[7:0], s_tuser[3], s_tdata[11:8]);
			if (m_tvalid && m_tready) begin
				reports_seen <= reports_seen + 1;
				if (expected_reports.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected report, expected none, actual tag %0d",
						$time, m_tuser[4:0]);
				end else begin
					report_t e;
					e = expected_reports.pop_front();
					check_field("tag", e.tag, m_tuser[4:0]);
					check_field("key", e.key, m_tdata[7:0]);
					check_field("value_a", e.value_a, m_tdata[23:8]);
					check_field("value_b", e.value_b, m_tdata[31:24]);
					check_field("value_c", e.value_c, m_tdata[39:32]);
					check_field("value_d", e.value_d, m_tdata[43:40]);
					check_field("position", e.position, m_tdata[51:44]);
					check_field("error", e.error, m_tuser[5]);
					check_field("segment_done", e.segment_done, m_tlast);
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("jpeg_header_segment_parser regression: fail");
				$finish;
			end
		end
	end

	// ---------------- test sequence ----------------
	initial begin
		ph = PH_IDLE; seg_kind = '0; seg_pos = '0; seg_left = '0; held = '0; cur_id = '0;
		n_items = '0; tclass = '0; pq = '0; ent = '0; sym_total = '0;

		// stray bytes before any start
		repeat (3) begin put(8'($urandom)); flush_seg(0, 0, 0); end
		seg_jfif(-1);                      flush_seg(0, 2, 0);
		seg_jfif(0);                       flush_seg(0, 1, 0);
		seg_jfif(4);                       flush_seg(0, 0, 0);
		seg_com(0, 16'd0);                 flush_seg(0, 1, 0);
		seg_com(0, 16'd2);                 flush_seg(0, 0, 0);
		seg_com(3, 16'd5);                 flush_seg(0, 0, 0);
		seg_frame(0);                      flush_seg(0, 0, 0);
		seg_frame(2);                      flush_seg(0, 0, 0);
		seg_scan(0);                       flush_seg(0, 0, 0);
		seg_scan(2);                       flush_seg(0, 0, 0);
		seg_quant(1, 0);                   flush_seg(0, 0, 0);
		seg_quant(2, 1);                   flush_seg(0, 1, 0);
		seg_huff(1, 0, 0);                 flush_seg(0, 0, 0);
		seg_huff(2, 4, 0);                 flush_seg(0, 0, 0);
		seg_huff(1, 40, 1);                flush_seg(0, 0, 0);
		open_seg(3'd6, 16'hFFFF); put(8'hFF); flush_seg(0, 0, 0);
		open_seg(3'd7, 16'h0000); put(8'h00); flush_seg(0, 0, 0);
		seg_frame(3);                      flush_seg(1, 0, 0);
		seg_com(2, 16'hFFFF);              flush_seg(1, 0, 1);
		seg_frame(40);                     flush_seg(0, 0, 0);

		while (header_bytes.size() < 1200) begin
			case ($urandom_range(0, 9))
				0: seg_jfif(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : -1);
				1: seg_com($urandom_range(0, 12), 16'd0);
				2: seg_frame($urandom_range(0, 4));
				3: seg_scan($urandom_range(0, 4));
				4: seg_quant($urandom_range(1, 2), $urandom_range(0, 3) == 0);
				5, 6: seg_huff($urandom_range(1, 3), 3, $urandom_range(0, 3) == 0);
				7: begin
					open_seg(3'($urandom_range(6, 7)), 16'($urandom));
					put(8'($urandom));
				end
				default: seg_scan($urandom_range(1, 3));
			endcase
			// comment lengths are fixed up here so most segments are well-formed
			if (segment_bytes[0].kind == K_COM && segment_bytes[0].start) begin
				int n;
				n = segment_bytes.size() - 2;
				if ($urandom_range(0, 4) != 0)
					{segment_bytes[0].data_byte, segment_bytes[1].data_byte} = 16'(n + 2);
			end
			flush_seg($urandom_range(0, 9) == 0, $urandom_range(0, 3) == 0 ? 2 : 0,
				$urandom_range(0, 40) == 0);
		end

		repeat (7) @(posedge clk);
		arst_n <= 1;
		wait (header_bytes.size() == 0 && !s_tvalid && expected_reports.size() == 0);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_reports.size() == 0)
			$display("jpeg_header_segment_parser regression: pass");
		else
			$display("jpeg_header_segment_parser regression: fail");
		$finish;
	end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/core/jhsp_pkg.sv
rtl/core/jhsp_core.sv
rtl/core/jpeg_header_segment_parser.sv
test/jpeg_header_segment_parser_test.sv
